// File: rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the circle raster painter: item structs,
// function codes, register indexes and the per-operation shape descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

  localparam int MAX_SIDE_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int COORD_W    = 24;
  localparam int RMAG_W     = COORD_W - 1;
  localparam int RSQ_W      = 2 * RMAG_W;
  localparam int CHAR_W     = 8;
  localparam int RC_W       = 8;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int SIDE_RST = 256;
  localparam logic [CHAR_W-1:0] BG_RST = 8'd32;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic                      filled;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] radius;
    logic [CHAR_W-1:0]         paint_char;
    logic [RC_W-1:0]           read_row;
    logic [RC_W-1:0]           read_col;
  } crp_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_value;
    logic              status;
  } crp_out_t;

  typedef struct packed {
    logic                      is_clear;
    logic                      filled;
    logic                      all_edge;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RSQ_W-1:0]          r2;
    logic [RSQ_W-1:0]          inner;
    logic [CHAR_W-1:0]         wchar;
  } crp_shape_t;

endpackage

`default_nettype wire

// File: rtl/circle_raster_painter_core.sv
// ----------------------------------------------------------------------------
// circle_raster_painter_core
// Character canvas in one synchronous RAM; clear and circle draw scan every
// pixel in use through the distance pipeline, read returns one pixel.
// Clear and draw make at most one write per cycle (set by the single RAM write
//   port); a read passes the RAM read register and ST_READ; zero or negative
//   radius, unused codes: result in the next cycle. One item at a time; busy while working.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset clears control and the config registers only; the canvas holds garbage until
//   the first clear, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_raster_painter_core
  import crp_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire crp_in_t               in_item,
  output logic                       out_valid,
  output crp_out_t                   out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDE_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int CNT_W     = $clog2(MAX_SIDE + 1);
  localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam logic [CNT_W-1:0] SIDE_RST_C =
    CNT_W'((MAX_SIDE < SIDE_RST) ? MAX_SIDE : SIDE_RST);
  localparam logic signed [COORD_W:0] ONE_S = (COORD_W+1)'(1 << FRAC_BITS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } crp_state_t;

  crp_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  width_r, height_r;
  logic [CHAR_W-1:0] bg_r;
  logic [CNT_W-1:0]  cfg_side;

  crp_in_t           item_r;
  logic [RSQ_W-1:0]  r2_r, inner_r;
  logic              all_edge_r;
  logic [SIDE_W-1:0] scan_row_r, scan_row_nxt;
  logic [SIDE_W-1:0] scan_col_r, scan_col_nxt;

  logic              out_valid_r, out_valid_nxt;
  crp_out_t          out_item_r, out_item_nxt;

  logic              accept;
  logic              rd_in_range;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data_r;
  logic              rd_ok_r;

  logic [CHAR_W-1:0] canvas_mem [MEM_DEPTH];

  logic                     scan_last_col;
  logic                     scan_last;
  logic signed [COORD_W:0]  r_minus_one;
  logic [RMAG_W-1:0]        rmag;
  logic [RMAG_W-1:0]        rmag_in;
  crp_shape_t               shape;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [CHAR_W-1:0]        wr_data;
  logic                     pipe_busy;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_side = CNT_W'(1);
    end else if (32'(cfg_wdata) > MAX_SIDE) begin
      cfg_side = CNT_W'(MAX_SIDE);
    end else begin
      cfg_side = CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_RST_C;
      height_r <= SIDE_RST_C;
      bg_r     <= BG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_side;
        CFG_HEIGHT: height_r <= cfg_side;
        CFG_BG:     bg_r     <= cfg_wdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_in_range = (CNT_W'(in_item.read_row) < height_r) &&
                  (CNT_W'(in_item.read_col) < width_r) &&
                  (32'(in_item.read_row) < MAX_SIDE) &&
                  (32'(in_item.read_col) < MAX_SIDE);
    rd_en   = accept && (in_item.func == FUNC_READ) && rd_in_range;
    rd_addr = ADDR_W'(ADDR_W'(in_item.read_row) * MAX_SIDE + ADDR_W'(in_item.read_col));
  end

  // Reads happen only while idle with the pipeline drained: no forwarding.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      canvas_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= canvas_mem[rd_addr];
    end
  end

  always_comb begin
    r_minus_one = {item_r.radius[COORD_W-1], item_r.radius} - ONE_S;
    rmag        = item_r.radius[RMAG_W-1:0];
    rmag_in     = r_minus_one[RMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      rd_ok_r <= rd_in_range;
    end
    if (state_r == ST_SETUP) begin
      r2_r       <= rmag * rmag;
      inner_r    <= (r_minus_one > 0) ? rmag_in * rmag_in : '0;
      all_edge_r <= !(r_minus_one > 0);
    end
  end

  always_comb begin
    shape.is_clear = (item_r.func == FUNC_CLEAR);
    shape.filled   = item_r.filled;
    shape.all_edge = all_edge_r;
    shape.cx       = item_r.center_x;
    shape.cy       = item_r.center_y;
    shape.r2       = r2_r;
    shape.inner    = inner_r;
    shape.wchar    = (item_r.func == FUNC_CLEAR) ? bg_r : item_r.paint_char;
  end

  crp_dist_pipe #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_vld (state_r == ST_SCAN),
    .issue_row (scan_row_r),
    .issue_col (scan_col_r),
    .shape     (shape),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .pipe_busy (pipe_busy)
  );

  always_comb begin
    scan_last_col = (CNT_W'(scan_col_r) == width_r - CNT_W'(1));
    scan_last     = scan_last_col && (CNT_W'(scan_row_r) == height_r - CNT_W'(1));

    state_nxt     = state_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.func)
            FUNC_CLEAR: state_nxt = ST_SCAN;
            FUNC_DRAW: begin
              if (in_item.radius > 0) begin
                state_nxt = ST_SETUP;
              end else begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = (in_item.radius == '0);
              end
            end
            FUNC_READ: state_nxt = ST_READ;
            default:   out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_SETUP: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_last_col) begin
          scan_col_nxt = '0;
          scan_row_nxt = scan_last ? '0 : scan_row_r + SIDE_W'(1);
        end else begin
          scan_col_nxt = scan_col_r + SIDE_W'(1);
        end
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.pixel_value = rd_ok_r ? rd_data_r : '0;
        state_nxt                = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/crp_dist_pipe.sv
// ----------------------------------------------------------------------------
// crp_dist_pipe
// Three-stage squared-distance pipeline: takes one scan position a cycle and
// produces the canvas write for it (clear, filled disc or outline).
// ----------------------------------------------------------------------------
`default_nettype none

module crp_dist_pipe
  import crp_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst_n,
  input  wire logic                                               issue_vld,
  input  wire logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] issue_row,
  input  wire logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] issue_col,
  input  wire crp_shape_t                                         shape,
  output logic                                                    wr_en,
  output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] wr_addr,
  output logic [CHAR_W-1:0]                                       wr_data,
  output logic                                                    pipe_busy
);

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int M_W    = (SIDE_W + FRAC_BITS > COORD_W - 1) ? SIDE_W + FRAC_BITS
                                                             : COORD_W - 1;
  localparam int D_W    = M_W + 2;
  localparam int ABS_W  = D_W - 1;
  localparam int SQ_W   = 2 * ABS_W + 1;

  logic signed [D_W-1:0] diff_x;
  logic signed [D_W-1:0] diff_y;
  logic [ABS_W-1:0]      abs_x;
  logic [ABS_W-1:0]      abs_y;
  logic [ADDR_W-1:0]     issue_addr;

  logic                  s1_vld_r, s2_vld_r, s3_vld_r;
  logic [ADDR_W-1:0]     s1_addr_r, s2_addr_r, s3_addr_r;
  logic [ABS_W-1:0]      s1_dx_r, s1_dy_r;
  logic [2*ABS_W-1:0]    s2_dx2_r, s2_dy2_r;
  logic [SQ_W-1:0]       s3_d2_r;

  logic [SQ_W-1:0]       r2_ext;
  logic [SQ_W-1:0]       inner_ext;
  logic                  in_disc;
  logic                  edge_hit;
  logic                  paint;

  always_comb begin
    diff_x = $signed(D_W'(issue_col) << FRAC_BITS) - D_W'(shape.cx);
    diff_y = $signed(D_W'(issue_row) << FRAC_BITS) - D_W'(shape.cy);
    abs_x  = diff_x[D_W-1] ? ABS_W'(-diff_x) : ABS_W'(diff_x);
    abs_y  = diff_y[D_W-1] ? ABS_W'(-diff_y) : ABS_W'(diff_y);
    issue_addr = ADDR_W'(ADDR_W'(issue_row) * MAX_SIDE + ADDR_W'(issue_col));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= issue_addr;
    s1_dx_r   <= abs_x;
    s1_dy_r   <= abs_y;
    s2_addr_r <= s1_addr_r;
    s2_dx2_r  <= s1_dx_r * s1_dx_r;
    s2_dy2_r  <= s1_dy_r * s1_dy_r;
    s3_addr_r <= s2_addr_r;
    s3_d2_r   <= SQ_W'(s2_dx2_r) + SQ_W'(s2_dy2_r);
  end

  always_comb begin
    r2_ext    = SQ_W'(shape.r2);
    inner_ext = SQ_W'(shape.inner);
    in_disc   = (s3_d2_r <= r2_ext);
    edge_hit  = in_disc && (shape.all_edge || (s3_d2_r >= inner_ext));
    paint     = edge_hit || (shape.filled && in_disc);
    wr_en     = s3_vld_r && (shape.is_clear || paint);
    wr_addr   = s3_addr_r;
    wr_data   = shape.wchar;
    pipe_busy = s1_vld_r || s2_vld_r || s3_vld_r;
  end

endmodule

`default_nettype wire
